// ===== rtl/plcp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plcp_pkg
// Shared constants, types and the exp2 stage table for the current profile.
// ---------------------------------------------------------------------------
package plcp_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int LOG_EXP_STAGES = 16;

  localparam int DIV_CELLS = FRAC_BITS + 1;
  localparam int R_W       = FRAC_BITS + 1;
  localparam int P_W       = $clog2(FRAC_BITS + 1);
  localparam int LM_W      = LOG_EXP_STAGES + P_W;
  localparam int U_W       = LM_W + 4;
  localparam int Q_W       = U_W - LOG_EXP_STAGES;
  localparam int M_W       = 31;
  localparam int ACC_W     = 33;
  localparam int PW_W      = FRAC_BITS + 1;
  localparam int PRD_W     = 33 + PW_W + 1;
  localparam int SPD_W     = 35;
  localparam int VM_W      = SPD_W + 16;

  localparam logic [2:0] REG_NORMAL    = 3'd0;
  localparam logic [2:0] REG_DIRECTION = 3'd1;
  localparam logic [2:0] REG_MEAN      = 3'd2;
  localparam logic [2:0] REG_DEPTH     = 3'd3;
  localparam logic [2:0] REG_SURFACE   = 3'd4;
  localparam logic [2:0] REG_SEABED    = 3'd5;
  localparam logic [2:0] REG_INV_EXP   = 3'd6;

  typedef struct packed {
    logic above;
    logic below;
    logic rzero;
  } tag_t;

  typedef logic [31:0] exp_tab_t [0:LOG_EXP_STAGES];

  function automatic exp_tab_t calc_exp_tab();
    exp_tab_t    t;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    t[0] = 32'h8000_0000;
    for (int b = 1; b <= LOG_EXP_STAGES; b++) begin
      x   = {t[b-1], 32'h0};
      res = 64'h0;
      bt  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (x >= res + bt) begin
          x   = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      t[b] = res[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = calc_exp_tab();

endpackage

// ===== rtl/plcp_div_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plcp_div_cell
// One restoring divide step: yields one quotient bit of the height ratio.
// ---------------------------------------------------------------------------
module plcp_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [30:0]           divisor,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_rem,
  input  logic [plcp_pkg::R_W-1:0] in_quo,
  input  plcp_pkg::tag_t        in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_rem,
  output logic [plcp_pkg::R_W-1:0] out_quo,
  output plcp_pkg::tag_t        out_tag
);
  import plcp_pkg::*;

  logic             v_r;
  logic [31:0]      rem_r, rem_nxt, diff;
  logic [R_W-1:0]   quo_r, quo_nxt;
  tag_t             tag_r;
  logic             ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    ge      = in_rem >= {1'b0, divisor};
    diff    = ge ? (in_rem - {1'b0, divisor}) : in_rem;
    rem_nxt = {diff[30:0], 1'b0};
    quo_nxt = {in_quo[R_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_tag   = tag_r;

endmodule

// ===== rtl/plcp_log_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plcp_log_cell
// One log2 squaring step: squares the mantissa and emits one fraction bit.
// ---------------------------------------------------------------------------
module plcp_log_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [plcp_pkg::M_W-1:0] in_m,
  input  logic [plcp_pkg::LOG_EXP_STAGES-1:0] in_frac,
  input  logic [plcp_pkg::P_W-1:0] in_p,
  input  plcp_pkg::tag_t        in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [plcp_pkg::M_W-1:0] out_m,
  output logic [plcp_pkg::LOG_EXP_STAGES-1:0] out_frac,
  output logic [plcp_pkg::P_W-1:0] out_p,
  output plcp_pkg::tag_t        out_tag
);
  import plcp_pkg::*;

  logic                      v_r;
  logic [2*M_W-1:0]          sq;
  logic [31:0]               sq_sh;
  logic [M_W-1:0]            m_r, m_nxt;
  logic [LOG_EXP_STAGES-1:0] frac_r, frac_nxt;
  logic [P_W-1:0]            p_r;
  tag_t                      tag_r;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    sq       = (2*M_W)'(in_m) * (2*M_W)'(in_m);
    sq_sh    = sq[61:30];
    m_nxt    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
    frac_nxt = {in_frac[LOG_EXP_STAGES-2:0], sq_sh[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
      p_r    <= in_p;
      tag_r  <= in_tag;
    end
  end

  assign out_valid = v_r;
  assign out_m     = m_r;
  assign out_frac  = frac_r;
  assign out_p     = p_r;
  assign out_tag   = tag_r;

endmodule

// ===== rtl/plcp_exp_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plcp_exp_cell
// One exp2 step: multiplies the accumulator by its table factor when the
// leading fraction bit is set.
// ---------------------------------------------------------------------------
module plcp_exp_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           factor,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [plcp_pkg::ACC_W-1:0] in_acc,
  input  logic [plcp_pkg::LOG_EXP_STAGES-1:0] in_f,
  input  logic [plcp_pkg::Q_W-1:0] in_q,
  input  plcp_pkg::tag_t        in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [plcp_pkg::ACC_W-1:0] out_acc,
  output logic [plcp_pkg::LOG_EXP_STAGES-1:0] out_f,
  output logic [plcp_pkg::Q_W-1:0] out_q,
  output plcp_pkg::tag_t        out_tag
);
  import plcp_pkg::*;

  logic                      v_r;
  logic [ACC_W+31:0]         prod;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [LOG_EXP_STAGES-1:0] f_r;
  logic [Q_W-1:0]            q_r;
  tag_t                      tag_r;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    prod    = (ACC_W+32)'(in_acc) * (ACC_W+32)'(factor);
    acc_nxt = in_f[LOG_EXP_STAGES-1] ? prod[ACC_W+31:32] : in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_r <= acc_nxt;
      f_r   <= {in_f[LOG_EXP_STAGES-2:0], 1'b0};
      q_r   <= in_q;
      tag_r <= in_tag;
    end
  end

  assign out_valid = v_r;
  assign out_acc   = acc_r;
  assign out_f     = f_r;
  assign out_q     = q_r;
  assign out_tag   = tag_r;

endmodule

// ===== rtl/power_law_current_profile.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// power_law_current_profile
// Power-law current velocity at a 3D position, fully pipelined.
// ---------------------------------------------------------------------------
// Usage: present a Q15.16 position on in_pos_x/y/z with in_valid; it is taken
// on a transfer (in_valid and in_ready high). Each position yields exactly one
// result on out_vel_x/y/z, out_above_water and out_below_seabed, delivered by
// a transfer on out_valid/out_ready, in input order.
// Pipeline: stages 0 and 1, the divide cells, stage 2, the log2 squaring cells,
// stage 3, the exp2 cells, then stages 4 to 8.
// Throughput: one position per cycle while out_ready is high. Every stage has
// its own valid bit, so a stalled receiver holds only the stages that are full;
// empty stages keep taking new positions until the pipeline has filled.
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
// high, only while the pipeline is empty.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults: normal +x, direction +z, depth 10 m, exponent 1.0.
// ---------------------------------------------------------------------------
module power_law_current_profile (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic               out_above_water,
  output logic               out_below_seabed
);
  import plcp_pkg::*;

  // configuration
  logic [47:0] normal_r, direction_r;
  logic [31:0] mean_r, surface_r, seabed_r;
  logic [30:0] depth_r, depth_eff;
  logic [15:0] inv_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r    <= 48'd16384;
      direction_r <= 48'd16384 << 32;
      mean_r      <= 32'd0;
      depth_r     <= 31'd655360;
      surface_r   <= 32'd0;
      seabed_r    <= 32'd0;
      inv_exp_r   <= 16'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NORMAL:    normal_r    <= cfg_wdata;
        REG_DIRECTION: direction_r <= cfg_wdata;
        REG_MEAN:      mean_r      <= cfg_wdata[31:0];
        REG_DEPTH:     depth_r     <= cfg_wdata[30:0];
        REG_SURFACE:   surface_r   <= cfg_wdata[31:0];
        REG_SEABED:    seabed_r    <= cfg_wdata[31:0];
        REG_INV_EXP:   inv_exp_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign depth_eff = (depth_r == 31'd0) ? 31'd1 : depth_r;

  // stage 0: projection products
  logic               v0_r, rdy0, rdy1;
  logic signed [47:0] pm_r [3];

  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      pm_r[0] <= 48'(in_pos_x) * 48'($signed(normal_r[15:0]));
      pm_r[1] <= 48'(in_pos_y) * 48'($signed(normal_r[31:16]));
      pm_r[2] <= 48'(in_pos_z) * 48'($signed(normal_r[47:32]));
    end
  end

  // stage 1: level compare and ratio numerator
  logic               v1_r;
  logic signed [49:0] dot_sum;
  logic signed [35:0] dot;
  logic signed [37:0] num;
  logic               above_nxt, below_nxt;
  logic [31:0]        rem1_r;
  tag_t               tag1_r;

  logic              dv_valid [DIV_CELLS+1];
  logic              dv_ready [DIV_CELLS+1];
  logic [31:0]       dv_rem   [DIV_CELLS+1];
  logic [R_W-1:0]    dv_quo   [DIV_CELLS+1];
  tag_t              dv_tag   [DIV_CELLS+1];

  always_comb begin
    dot_sum   = 50'(pm_r[0]) + 50'(pm_r[1]) + 50'(pm_r[2]);
    dot       = 36'(dot_sum >>> 14);
    above_nxt = dot > 36'($signed(mean_r));
    num       = 38'(dot) - 38'($signed(mean_r)) + 38'({1'b0, depth_r});
    below_nxt = num[37];
  end

  assign rdy1 = !v1_r || dv_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v0_r && rdy1) begin
      rem1_r <= (above_nxt || below_nxt) ? 32'd0 : num[31:0];
      tag1_r <= '{above: above_nxt, below: below_nxt && !above_nxt, rzero: 1'b0};
    end
  end

  // divide chain
  assign dv_valid[0] = v1_r;
  assign dv_rem[0]   = rem1_r;
  assign dv_quo[0]   = '0;
  assign dv_tag[0]   = tag1_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    plcp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (depth_eff),
      .in_valid  (dv_valid[i]),
      .in_ready  (dv_ready[i]),
      .in_rem    (dv_rem[i]),
      .in_quo    (dv_quo[i]),
      .in_tag    (dv_tag[i]),
      .out_valid (dv_valid[i+1]),
      .out_ready (dv_ready[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_quo   (dv_quo[i+1]),
      .out_tag   (dv_tag[i+1])
    );
  end

  // stage 2: normalise ratio
  logic                      v2_r, rdy2;
  logic [R_W-1:0]            r_val;
  logic [P_W-1:0]            p_nxt, p2_r;
  logic [M_W-1:0]            m2_r;
  tag_t                      tag2_r;

  logic                      lg_valid [LOG_EXP_STAGES+1];
  logic                      lg_ready [LOG_EXP_STAGES+1];
  logic [M_W-1:0]            lg_m     [LOG_EXP_STAGES+1];
  logic [LOG_EXP_STAGES-1:0] lg_frac  [LOG_EXP_STAGES+1];
  logic [P_W-1:0]            lg_p     [LOG_EXP_STAGES+1];
  tag_t                      lg_tag   [LOG_EXP_STAGES+1];

  assign r_val = dv_quo[DIV_CELLS];

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < R_W; i++) begin
      if (r_val[i]) begin
        p_nxt = P_W'(i);
      end
    end
  end

  assign rdy2                 = !v2_r || lg_ready[0];
  assign dv_ready[DIV_CELLS]  = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= dv_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_valid[DIV_CELLS] && rdy2) begin
      m2_r   <= M_W'(r_val) << (5'd30 - 5'(p_nxt));
      p2_r   <= p_nxt;
      tag2_r <= '{above: dv_tag[DIV_CELLS].above, below: dv_tag[DIV_CELLS].below,
                  rzero: (r_val == '0)};
    end
  end

  // log2 chain
  assign lg_valid[0] = v2_r;
  assign lg_m[0]     = m2_r;
  assign lg_frac[0]  = '0;
  assign lg_p[0]     = p2_r;
  assign lg_tag[0]   = tag2_r;

  for (genvar i = 0; i < LOG_EXP_STAGES; i++) begin : g_log
    plcp_log_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lg_valid[i]),
      .in_ready  (lg_ready[i]),
      .in_m      (lg_m[i]),
      .in_frac   (lg_frac[i]),
      .in_p      (lg_p[i]),
      .in_tag    (lg_tag[i]),
      .out_valid (lg_valid[i+1]),
      .out_ready (lg_ready[i+1]),
      .out_m     (lg_m[i+1]),
      .out_frac  (lg_frac[i+1]),
      .out_p     (lg_p[i+1]),
      .out_tag   (lg_tag[i+1])
    );
  end

  // stage 3: scale log by exponent
  logic                      v3_r, rdy3;
  logic [P_W-1:0]            lm_hi;
  logic [LM_W-1:0]           lm;
  logic [LM_W+15:0]          lm_prod;
  logic [U_W-1:0]            u3_r;
  tag_t                      tag3_r;

  logic                      ex_valid [LOG_EXP_STAGES+1];
  logic                      ex_ready [LOG_EXP_STAGES+1];
  logic [ACC_W-1:0]          ex_acc   [LOG_EXP_STAGES+1];
  logic [LOG_EXP_STAGES-1:0] ex_f     [LOG_EXP_STAGES+1];
  logic [Q_W-1:0]            ex_q     [LOG_EXP_STAGES+1];
  tag_t                      ex_tag   [LOG_EXP_STAGES+1];

  always_comb begin
    lm_hi   = P_W'(FRAC_BITS) - lg_p[LOG_EXP_STAGES];
    lm      = {lm_hi, {LOG_EXP_STAGES{1'b0}}} - LM_W'(lg_frac[LOG_EXP_STAGES]);
    lm_prod = (LM_W+16)'(lm) * (LM_W+16)'(inv_exp_r);
  end

  assign rdy3                     = !v3_r || ex_ready[0];
  assign lg_ready[LOG_EXP_STAGES] = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= lg_valid[LOG_EXP_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (lg_valid[LOG_EXP_STAGES] && rdy3) begin
      u3_r   <= lm_prod[LM_W+15:12];
      tag3_r <= lg_tag[LOG_EXP_STAGES];
    end
  end

  // exp2 chain
  assign ex_valid[0] = v3_r;
  assign ex_acc[0]   = ACC_W'(1) << 32;
  assign ex_f[0]     = u3_r[LOG_EXP_STAGES-1:0];
  assign ex_q[0]     = u3_r[U_W-1:LOG_EXP_STAGES];
  assign ex_tag[0]   = tag3_r;

  for (genvar i = 0; i < LOG_EXP_STAGES; i++) begin : g_exp
    plcp_exp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .factor    (EXP_TAB[i+1]),
      .in_valid  (ex_valid[i]),
      .in_ready  (ex_ready[i]),
      .in_acc    (ex_acc[i]),
      .in_f      (ex_f[i]),
      .in_q      (ex_q[i]),
      .in_tag    (ex_tag[i]),
      .out_valid (ex_valid[i+1]),
      .out_ready (ex_ready[i+1]),
      .out_acc   (ex_acc[i+1]),
      .out_f     (ex_f[i+1]),
      .out_q     (ex_q[i+1]),
      .out_tag   (ex_tag[i+1])
    );
  end

  // stage 4: integer shift, power
  logic              v4_r, rdy4;
  logic [ACC_W-1:0]  acc_sh;
  logic [PW_W-1:0]   pw_nxt, pw4_r;
  tag_t              tag4_r;

  always_comb begin
    acc_sh = ex_acc[LOG_EXP_STAGES] >> ex_q[LOG_EXP_STAGES];
    if (ex_tag[LOG_EXP_STAGES].rzero) begin
      pw_nxt = (inv_exp_r == 16'd0) ? (PW_W'(1) << FRAC_BITS) : '0;
    end else if (ex_q[LOG_EXP_STAGES] >= Q_W'(40)) begin
      pw_nxt = '0;
    end else begin
      pw_nxt = acc_sh[32:32-FRAC_BITS];
    end
  end

  assign ex_ready[LOG_EXP_STAGES] = rdy4;

  // stages 5 to 8
  logic                   v5_r, v6_r, v7_r, v8_r, rdy5, rdy6, rdy7, rdy8;
  logic signed [32:0]     diff;
  logic signed [PRD_W-1:0] prod5_r;
  logic signed [SPD_W-1:0] speed6_r;
  logic signed [VM_W-1:0]  vm7_r [3];
  logic signed [31:0]      vel8_r [3];
  logic                    above8_r, below8_r;
  tag_t                    tag5_r, tag6_r, tag7_r;

  assign rdy4 = !v4_r || rdy5;
  assign rdy5 = !v5_r || rdy6;
  assign rdy6 = !v6_r || rdy7;
  assign rdy7 = !v7_r || rdy8;
  assign rdy8 = !v8_r || out_ready;

  assign diff = 33'($signed(surface_r)) - 33'($signed(seabed_r));

  function automatic logic signed [31:0] sat32(input logic signed [VM_W-15:0] v);
    if (v > (VM_W-14)'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -(VM_W-14)'(33'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= ex_valid[LOG_EXP_STAGES];
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
      if (rdy8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid[LOG_EXP_STAGES] && rdy4) begin
      pw4_r  <= pw_nxt;
      tag4_r <= ex_tag[LOG_EXP_STAGES];
    end
    if (v4_r && rdy5) begin
      prod5_r <= PRD_W'(diff) * PRD_W'($signed({1'b0, pw4_r}));
      tag5_r  <= tag4_r;
    end
    if (v5_r && rdy6) begin
      speed6_r <= SPD_W'($signed(seabed_r)) + SPD_W'(prod5_r >>> FRAC_BITS);
      tag6_r   <= tag5_r;
    end
    if (v6_r && rdy7) begin
      vm7_r[0] <= VM_W'(speed6_r) * VM_W'($signed(direction_r[15:0]));
      vm7_r[1] <= VM_W'(speed6_r) * VM_W'($signed(direction_r[31:16]));
      vm7_r[2] <= VM_W'(speed6_r) * VM_W'($signed(direction_r[47:32]));
      tag7_r   <= tag6_r;
    end
    if (v7_r && rdy8) begin
      for (int k = 0; k < 3; k++) begin
        vel8_r[k] <= tag7_r.above ? 32'sd0 : sat32((VM_W-14)'(vm7_r[k] >>> 14));
      end
      above8_r <= tag7_r.above;
      below8_r <= tag7_r.below;
    end
  end

  assign out_valid        = v8_r;
  assign out_vel_x        = vel8_r[0];
  assign out_vel_y        = vel8_r[1];
  assign out_vel_z        = vel8_r[2];
  assign out_above_water  = above8_r;
  assign out_below_seabed = below8_r;

`ifndef SYNTHESIS
  a_above_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_above_water |->
      out_vel_x == 0 && out_vel_y == 0 && out_vel_z == 0 && !out_below_seabed)
    else $error("above-water result carries velocity");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> in_ready)
    else $error("empty front stage refuses a transfer");

  a_take_front : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v0_r)
    else $error("accepted position lost at front stage");
`endif

endmodule
